// ----- hw/rtl/toc_pkg.sv -----
// ----------------------------------------------------------------------------
// toc_pkg: shared types, constants and functions
// fixed-point constants, cordic lane types and step angle table function
// ----------------------------------------------------------------------------
package toc_pkg;

  localparam int unsigned COORD_BITS     = 16;
  localparam int unsigned AREA_FRAC_BITS = 16;
  localparam int unsigned CORDIC_STEPS   = 32;
  localparam int unsigned ANGLE_FRAC     = 32;
  localparam int unsigned CORDIC_GUARD   = 60 - 2 * COORD_BITS;
  localparam int unsigned AREA_SHIFT     = ANGLE_FRAC - AREA_FRAC_BITS;
  localparam int unsigned AREA_BITS      = 51;
  localparam int unsigned STEP_BITS      = 6;

  localparam logic [34:0]        PI_Q32         = 35'd13493037705;
  localparam logic signed [36:0] HALF_PI_Q32    = 37'sd6746518852;
  localparam logic signed [63:0] QUARTER_PI_Q32 = 64'sd3373259426;
  localparam logic [AREA_BITS-1:0] AREA_MAX     = {AREA_BITS{1'b1}};

  // result codes
  typedef enum logic [1:0] {
    CASE_CONTAINED = 2'd0,
    CASE_TOUCHING  = 2'd1,
    CASE_LENS      = 2'd2
  } case_e;

  // center register indexes
  typedef enum logic [1:0] {
    REG_A_X = 2'd0,
    REG_A_Y = 2'd1,
    REG_B_X = 2'd2,
    REG_B_Y = 2'd3
  } reg_e;

  // one cordic lane: vector and accumulated angle
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [36:0] z;
  } lane_t;

  // word moving along the cell chain
  typedef struct packed {
    logic        vld;
    case_e       kind;
    logic [33:0] ra2;
    logic [33:0] rb2;
    logic [34:0] c;
    lane_t       a;
    lane_t       b;
  } cell_t;

  // atan(2^-i) in Q32, taylor series in Q60 then rounded
  function automatic logic signed [63:0] atan_pow2(input int unsigned i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int unsigned        k;
    int unsigned        e;
    sum  = '0;
    term = '0;
    e    = 0;
    if (i == 0) begin
      return QUARTER_PI_Q32;
    end
    for (k = 0; k < 31; k++) begin
      if (i * (2 * k + 1) <= 60) begin
        e    = i * (2 * k + 1);
        term = (64'sd1 <<< (60 - e)) / 64'(2 * k + 1);
        sum  = (k % 2 == 1) ? sum - term : sum + term;
      end
    end
    return (sum + (64'sd1 <<< 27)) >>> 28;
  endfunction

  // scale the vector, pre-rotate into the right half plane
  function automatic lane_t cordic_init(input logic signed [34:0] d,
                                        input logic [34:0] c);
    lane_t             l;
    logic signed [63:0] x;
    logic signed [63:0] y;
    x = 64'(d) <<< CORDIC_GUARD;
    y = $signed({29'd0, c}) <<< CORDIC_GUARD;
    if (x < 0) begin
      l.x = y;
      l.y = -x;
      l.z = HALF_PI_Q32;
    end else begin
      l.x = x;
      l.y = y;
      l.z = '0;
    end
    return l;
  endfunction

endpackage

// ----- hw/rtl/two_circle_overlap_area_core.sv -----
// ----------------------------------------------------------------------------
// two_circle_overlap_area_core: overlap area of two circles through a point
// streaming core; configured centers A and B, one area word per query point
// ----------------------------------------------------------------------------
// each query point P defines circle A (radius |A-P|) and circle B (radius
// |B-P|); the core returns their common area as unsigned Q.16 (floor,
// saturating at 2^51-1) and a case code on m_axis_tuser: contained, touching
// or lens. one query enters per cycle while the pipeline is not stalled; its
// result word passes through 40 register stages: four front stages
// (differences, 17x17 products, sums, cordic seed), a chain of 32 cordic
// cells that work out both half-angles side by side, three back stages
// (squared radius times angle multiply, lens sum, floor and saturate) and the
// output register.
// the whole pipeline advances whenever the output register is empty or being
// taken, so m_axis_tready low while a result word waits stalls the whole chain.
// the user must write centers through the cfg port only while the core is idle;
// the core itself does not enforce this, and cfg_ready_o is always high.
module two_circle_overlap_area_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // query words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // query_x [15:0], query_y [31:16]
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // overlap_area [50:0], zero [55:51]
  output logic [1:0]  m_axis_tuser,   // overlap_case [1:0]
  // center registers
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import toc_pkg::*;

  logic signed [15:0] ax_q, ay_q, bx_q, by_q;
  logic               en;
  cell_t              chain [CORDIC_STEPS+1];
  logic               out_vld;
  logic [AREA_BITS-1:0] out_area;
  case_e              out_kind;
  logic               m_vld_q;
  logic [AREA_BITS-1:0] m_area_q;
  case_e              m_kind_q;

  // center registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
      ay_q <= '0;
      bx_q <= '0;
      by_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_A_X: ax_q <= cfg_data_i;
        REG_A_Y: ay_q <= cfg_data_i;
        REG_B_X: bx_q <= cfg_data_i;
        REG_B_Y: by_q <= cfg_data_i;
        default: ax_q <= ax_q;
      endcase
    end
  end

  // pipeline moves when the output slot is free or drains this cycle
  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  toc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .ax_i   (ax_q),
    .ay_i   (ay_q),
    .bx_i   (bx_q),
    .by_i   (by_q),
    .qx_i   (s_axis_tdata[15:0]),
    .qy_i   (s_axis_tdata[31:16]),
    .cell_o (chain[0])
  );

  // cordic chain, one rotation step per cell
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    toc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_BITS'(g)),
      .angle_i (37'(atan_pow2(g))),
      .cell_i  (chain[g]),
      .cell_o  (chain[g+1])
    );
  end

  toc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cell_i (chain[CORDIC_STEPS]),
    .vld_o  (out_vld),
    .area_o (out_area),
    .kind_o (out_kind)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= out_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_area_q <= out_area;
      m_kind_q <= out_kind;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {5'd0, m_area_q};
  assign m_axis_tuser  = m_kind_q;

endmodule

// ----- hw/rtl/toc_front.sv -----
// ----------------------------------------------------------------------------
// toc_front: geometry front end
// differences, products, radii, cross and dot products, case and cordic seed
// ----------------------------------------------------------------------------
module toc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic signed [15:0]       ax_i,
  input  logic signed [15:0]       ay_i,
  input  logic signed [15:0]       bx_i,
  input  logic signed [15:0]       by_i,
  input  logic signed [15:0]       qx_i,
  input  logic signed [15:0]       qy_i,
  output toc_pkg::cell_t           cell_o
);
  import toc_pkg::*;

  // stage 1: differences
  logic               s1_vld_q;
  logic signed [16:0] ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
  // stage 2: products
  logic               s2_vld_q;
  logic signed [33:0] cr1_q, cr2_q, vxx_q, vyy_q, wxx_q, wyy_q;
  logic signed [33:0] uvx_q, uvy_q, uwx_q, uwy_q, vwx_q, vwy_q;
  // stage 3: sums
  logic               s3_vld_q;
  logic signed [34:0] cr_q, da_q, db_q, dvw_q;
  logic [33:0]        ra2_q, rb2_q;
  // stage 4: seed for the chain
  cell_t              cell_d, cell_q;
  logic [34:0]        cabs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q  <= 17'(bx_i) - 17'(ax_i);
      uy_q  <= 17'(by_i) - 17'(ay_i);
      vx_q  <= 17'(qx_i) - 17'(ax_i);
      vy_q  <= 17'(qy_i) - 17'(ay_i);
      wx_q  <= 17'(qx_i) - 17'(bx_i);
      wy_q  <= 17'(qy_i) - 17'(by_i);
      cr1_q <= ux_q * vy_q;
      cr2_q <= uy_q * vx_q;
      vxx_q <= vx_q * vx_q;
      vyy_q <= vy_q * vy_q;
      wxx_q <= wx_q * wx_q;
      wyy_q <= wy_q * wy_q;
      uvx_q <= ux_q * vx_q;
      uvy_q <= uy_q * vy_q;
      uwx_q <= ux_q * wx_q;
      uwy_q <= uy_q * wy_q;
      vwx_q <= vx_q * wx_q;
      vwy_q <= vy_q * wy_q;
      cr_q  <= 35'(cr1_q) - 35'(cr2_q);
      ra2_q <= 34'(35'(vxx_q) + 35'(vyy_q));
      rb2_q <= 34'(35'(wxx_q) + 35'(wyy_q));
      da_q  <= 35'(uvx_q) + 35'(uvy_q);
      db_q  <= -(35'(uwx_q) + 35'(uwy_q));
      dvw_q <= 35'(vwx_q) + 35'(vwy_q);
    end
  end

  always_comb begin
    cabs       = cr_q[34] ? 35'(-cr_q) : 35'(cr_q);
    cell_d.vld = s3_vld_q;
    cell_d.ra2 = ra2_q;
    cell_d.rb2 = rb2_q;
    cell_d.c   = cabs;
    if (cr_q != '0) begin
      cell_d.kind = CASE_LENS;
    end else if (dvw_q >= 0) begin
      cell_d.kind = CASE_CONTAINED;
    end else begin
      cell_d.kind = CASE_TOUCHING;
    end
    cell_d.a = cordic_init(da_q, cabs);
    cell_d.b = cordic_init(db_q, cabs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- hw/rtl/toc_cell.sv -----
// ----------------------------------------------------------------------------
// toc_cell: one cordic vectoring step
// rotates both angle lanes toward the x axis and hands the word on
// ----------------------------------------------------------------------------
module toc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [toc_pkg::STEP_BITS-1:0] step_i,
  input  logic signed [36:0]           angle_i,
  input  toc_pkg::cell_t               cell_i,
  output toc_pkg::cell_t               cell_o
);
  import toc_pkg::*;

  cell_t cell_d, cell_q;

  function automatic lane_t rotate(input lane_t l, input logic [STEP_BITS-1:0] s,
                                   input logic signed [36:0] a);
    lane_t              r;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    dx = l.y >>> s;
    dy = l.x >>> s;
    if (l.y >= 0) begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + a;
    end else begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - a;
    end
    return r;
  endfunction

  always_comb begin
    cell_d   = cell_i;
    cell_d.a = rotate(cell_i.a, step_i, angle_i);
    cell_d.b = rotate(cell_i.b, step_i, angle_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- hw/rtl/toc_back.sv -----
// ----------------------------------------------------------------------------
// toc_back: area back end
// radius times angle products, lens sum, floor, clamp and saturation
// ----------------------------------------------------------------------------
module toc_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  toc_pkg::cell_t                    cell_i,
  output logic                              vld_o,
  output logic [toc_pkg::AREA_BITS-1:0]     area_o,
  output toc_pkg::case_e                    kind_o
);
  import toc_pkg::*;

  logic [34:0]        alpha, beta, na;
  logic [33:0]        ma, mb, rmin;
  logic [34:0]        csub;
  // stage 1
  logic               b1_vld_q;
  case_e              b1_kind_q;
  logic [68:0]        pa_q, pb_q;
  logic [34:0]        c_q;
  // stage 2
  logic               b2_vld_q;
  case_e              b2_kind_q;
  logic signed [70:0] t_q;
  // stage 3
  logic               b3_vld_q;
  case_e              b3_kind_q;
  logic [AREA_BITS-1:0] area_q, area_d;
  logic [54:0]        tsh;

  always_comb begin
    alpha = cell_i.a.z[36] ? '0 : cell_i.a.z[34:0];
    beta  = cell_i.b.z[36] ? '0 : cell_i.b.z[34:0];
    rmin  = (cell_i.ra2 < cell_i.rb2) ? cell_i.ra2 : cell_i.rb2;
    ma    = '0;
    na    = '0;
    mb    = '0;
    csub  = '0;
    case (cell_i.kind)
      CASE_LENS: begin
        ma   = cell_i.ra2;
        na   = alpha;
        mb   = cell_i.rb2;
        csub = cell_i.c;
      end
      CASE_CONTAINED: begin
        ma = rmin;
        na = PI_Q32;
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
    end else if (en_i) begin
      b1_vld_q <= cell_i.vld;
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= b2_vld_q;
    end
  end

  always_comb begin
    tsh = 55'(t_q >>> AREA_SHIFT);
    if (t_q < 0) begin
      area_d = '0;
    end else if (tsh > 55'(AREA_MAX)) begin
      area_d = AREA_MAX;
    end else begin
      area_d = tsh[AREA_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_kind_q <= cell_i.kind;
      pa_q      <= 69'(ma) * 69'(na);
      pb_q      <= 69'(mb) * 69'(beta);
      c_q       <= csub;
      b2_kind_q <= b1_kind_q;
      t_q       <= $signed({2'b00, pa_q}) + $signed({2'b00, pb_q})
                   - $signed({4'b0000, c_q, 32'd0});
      b3_kind_q <= b2_kind_q;
      area_q    <= area_d;
    end
  end

  assign vld_o  = b3_vld_q;
  assign area_o = area_q;
  assign kind_o = b3_kind_q;

endmodule

// ----- hw/rtl/toc_checker.sv -----
// ----------------------------------------------------------------------------
// toc_checker: port-level checks for the overlap area core
// case codes, touching results and flow control seen at the ports
// ----------------------------------------------------------------------------
module toc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import toc_pkg::*;

  // the unused case code never leaves the core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == CASE_CONTAINED || m_axis_tuser == CASE_TOUCHING
                       || m_axis_tuser == CASE_LENS))
    else $error("undefined case code");

  // circles meeting in one point overlap in nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == CASE_TOUCHING) |-> (m_axis_tdata == '0))
    else $error("touching result with nonzero area");

  // input side is open exactly when the output slot can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output");

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind two_circle_overlap_area_core toc_checker u_toc_checker (.*);

// ----- bench/two_circle_overlap_area_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_circle_overlap_area_checker: watches the core's channels and scores it
// tracks the center registers, predicts area and case for each query word
// and compares every result word with the oldest prediction
// ----------------------------------------------------------------------------
module two_circle_overlap_area_checker
  import toc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [AREA_BITS-1:0] area;
    case_e                kind;
  } overlap_t;

  overlap_t    overlap_q[$];
  logic [15:0] ax_r, ay_r, bx_r, by_r;
  longint      step_angle[CORDIC_STEPS];

  assign pending_o = overlap_q.size();

  // step angles, series in Q60 rounded to Q32
  initial begin
    longint acc;
    longint term;
    int     e;
    step_angle[0] = 64'sd3373259426;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      acc = 0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        e    = i * (2 * k + 1);
        term = (64'sd1 <<< (60 - e)) / longint'(2 * k + 1);
        acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
      step_angle[i] = (acc + (64'sd1 <<< 27)) >>> 28;
    end
  end

  function automatic longint half_angle(longint x, longint y);
    longint z;
    longint dx;
    longint dy;
    longint t;
    z = 0;
    x = x <<< CORDIC_GUARD;
    y = y <<< CORDIC_GUARD;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'sd6746518852;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += step_angle[i];
      end else begin
        x -= dx; y += dy; z -= step_angle[i];
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic logic [AREA_BITS-1:0] q32_to_area(logic [127:0] w);
    logic [127:0] v;
    if (w[127]) return '0;
    v = w >> AREA_SHIFT;
    return (v > 128'(AREA_MAX)) ? AREA_MAX : v[AREA_BITS-1:0];
  endfunction

  function automatic overlap_t predict_overlap(logic [15:0] qxw, logic [15:0] qyw);
    overlap_t     r;
    longint       ax, ay, bx, by, qx, qy, ux, uy, vx, vy, wx, wy, cr, ra2, rb2, c;
    longint       alpha, beta;
    logic [127:0] t;
    ax = longint'($signed(ax_r)); ay = longint'($signed(ay_r));
    bx = longint'($signed(bx_r)); by = longint'($signed(by_r));
    qx = longint'($signed(qxw));  qy = longint'($signed(qyw));
    ux = bx - ax; uy = by - ay;
    vx = qx - ax; vy = qy - ay;
    wx = qx - bx; wy = qy - by;
    cr  = ux * vy - uy * vx;
    ra2 = vx * vx + vy * vy;
    rb2 = wx * wx + wy * wy;
    if (cr == 0) begin
      if (vx * wx + vy * wy >= 0) begin
        r.kind = CASE_CONTAINED;
        t = 128'((ra2 < rb2) ? ra2 : rb2) * 128'(PI_Q32);
        r.area = q32_to_area(t);
      end else begin
        r.kind = CASE_TOUCHING;
        r.area = '0;
      end
    end else begin
      c     = (cr < 0) ? -cr : cr;
      alpha = half_angle(ux * vx + uy * vy, c);
      beta  = half_angle(-(ux * wx + uy * wy), c);
      t = 128'(ra2) * 128'(alpha) + 128'(rb2) * 128'(beta) - (128'(c) << ANGLE_FRAC);
      r.area = q32_to_area(t);
      r.kind = CASE_LENS;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    overlap_t want;
    if (!rst_ni) begin
      ax_r = '0; ay_r = '0; bx_r = '0; by_r = '0;
      overlap_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (overlap_q.size() == 0) begin
          report_mismatch("unexpected result word, area", m_axis_tdata[50:0], 0);
        end else begin
          want = overlap_q.pop_front();
          if (m_axis_tdata[50:0] !== want.area)
            report_mismatch("overlap_area", m_axis_tdata[50:0], want.area);
          if (m_axis_tuser !== want.kind)
            report_mismatch("overlap_case", m_axis_tuser, want.kind);
          if (m_axis_tdata[55:51] !== 5'd0)
            report_mismatch("tdata pad bits", m_axis_tdata[55:51], 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        overlap_q = {overlap_q, predict_overlap(s_axis_tdata[15:0], s_axis_tdata[31:16])};
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_A_X: ax_r = cfg_data_i;
          REG_A_Y: ay_r = cfg_data_i;
          REG_B_X: bx_r = cfg_data_i;
          REG_B_Y: by_r = cfg_data_i;
          default: ax_r = ax_r;
        endcase
      end
    end
  end

endmodule

// ----- bench/tb_two_circle_overlap_area_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_circle_overlap_area_core: stimulus and verdict for the overlap core
// several center settings, directed corner queries, then random and
// collinear queries with random gaps and back-pressure; the checker scores
// ----------------------------------------------------------------------------
module tb_two_circle_overlap_area_core;
  import toc_pkg::*;

  localparam int DRAIN_CYCLES = 60;    // pipeline is 40 registers deep plus margin
  localparam int RANDOM_PER_PHASE = 130;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  bit          no_gaps = 1'b0;   // long stretch without idling on either side
  int          words_sent = 0;
  int          phases_run = 0;
  logic signed [15:0] ax, ay, bx, by;

  always #4 clk_i = ~clk_i;

  two_circle_overlap_area_core u_dut (.*);

  two_circle_overlap_area_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls about 13 percent of the time
  always @(negedge clk_i)
    m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 13);

  // one query word; valid stays high across back-to-back words
  task automatic send_query(logic [15:0] qx, logic [15:0] qy);
    if (!no_gaps && $urandom_range(0, 99) < 13) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {qy, qx};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    words_sent++;
  endtask

  // wait for every result, then let the chain empty
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_center(logic [1:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_centers(logic [15:0] nax, logic [15:0] nay,
                             logic [15:0] nbx, logic [15:0] nby);
    drain_results();
    write_center(REG_A_X, nax);
    write_center(REG_A_Y, nay);
    write_center(REG_B_X, nbx);
    write_center(REG_B_Y, nby);
    ax = nax; ay = nay; bx = nbx; by = nby;
    phases_run++;
  endtask

  // point on the line through the centers, parameter k, if it fits 16 bits
  task automatic send_on_line(int k);
    longint px, py;
    px = longint'(ax) + k * (longint'(bx) - longint'(ax));
    py = longint'(ay) + k * (longint'(by) - longint'(ay));
    if (px >= -32768 && px <= 32767 && py >= -32768 && py <= 32767)
      send_query(px[15:0], py[15:0]);
    else
      send_query(ax, ay);
  endtask

  task automatic random_queries(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_query(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      else if (pick < 82)
        send_on_line(int'($urandom_range(0, 5)) - 2);
      else if (pick < 92)
        send_query(16'(int'(ax) + int'($urandom_range(0, 64)) - 32),
                   16'(int'(ay) + int'($urandom_range(0, 64)) - 32));
      else
        send_query(($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff,
                   ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff);
    end
  endtask

  // directed corners for the current centers
  task automatic directed_queries();
    send_query(ax, ay);                 // query on center a
    send_query(bx, by);                 // query on center b
    send_on_line(2);                    // collinear outside: contained
    send_on_line(-1);
    send_query(16'h8000, 16'h8000);
    send_query(16'h7fff, 16'h7fff);
    send_query(16'h8000, 16'h7fff);
    send_query(16'h7fff, 16'h8000);
    send_query(16'h0000, 16'h0000);
    send_query(16'hffff, 16'h0001);
    send_query(16'h5555, 16'haaaa);
    send_query(16'haaaa, 16'h5555);
  endtask

  initial begin
    ax = '0; ay = '0; bx = '0; by = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset centers: both at the origin, every query is contained
    phases_run = 1;
    directed_queries();
    random_queries(40);

    // distinct centers, between-the-centers touching point included
    set_centers(16'd100, 16'd0, 16'd300, 16'd0);
    directed_queries();
    send_query(16'd200, 16'd0);         // midway: touching
    send_query(16'd101, 16'd0);
    send_query(16'd200, 16'd1);         // thin lens
    drain_results();                    // sender holds off until all results are in
    random_queries(RANDOM_PER_PHASE);

    // extreme opposite corners
    set_centers(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    directed_queries();
    no_gaps = 1'b1;                     // no idling on either side
    random_queries(RANDOM_PER_PHASE);
    no_gaps = 1'b0;

    set_centers(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    directed_queries();
    random_queries(RANDOM_PER_PHASE);

    // equal centers away from the origin
    set_centers(16'd1234, 16'hfb2e, 16'd1234, 16'hfb2e);
    directed_queries();
    random_queries(RANDOM_PER_PHASE);

    for (int p = 0; p < 3; p++) begin
      set_centers(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      directed_queries();
      random_queries(RANDOM_PER_PHASE);
    end

    drain_results();
    $display("covered %0d query words over %0d center settings,", words_sent, phases_run);
    $display("with corner, on-center, collinear and random points under back-pressure");
    if (fail_count == 0 && pending == 0) begin
      $display("two_circle_overlap_area_core: match");
    end else begin
      $display("two_circle_overlap_area_core: mismatch");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4ms;
    $display("timeout with %0d results outstanding", pending);
    $display("two_circle_overlap_area_core: mismatch");
    $finish;
  end

endmodule
